[design/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types, constants and helpers for the RSA blind signature unit.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(WORD_WIDTH);
  localparam int unsigned REG_IDX_W  = 2;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t CNT_LAST = CNT_W'(WORD_WIDTH - 1);

  localparam word_t MODULUS_RST  = WORD_WIDTH'(3233);
  localparam word_t PUB_EXP_RST  = WORD_WIDTH'(17);
  localparam word_t PRIV_EXP_RST = WORD_WIDTH'(2753);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BLIND   = 2'd0,
    KIND_SIGN    = 2'd1,
    KIND_UNBLIND = 2'd2,
    KIND_VERIFY  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_POW_CHK,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_INV_CHK,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_FIN_MUL,
    ST_DONE
  } state_e;

  // handshake between the sequencer and a shared multi-cycle unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  // (x + y) mod n for x, y < n
  function automatic word_t add_mod(word_t x, word_t y, word_t n);
    logic [WORD_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[WORD_WIDTH-1:0];
  endfunction

endpackage

[design/rbs_cell.sv]
// ----------------------------------------------------------------------------
// rbs_cell
// One bit cell of an operand shift chain: parallel load or pass from neighbor.
// ----------------------------------------------------------------------------
module rbs_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic prev_bit_i,
  output logic bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = prev_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

[design/rbs_bit_chain.sv]
// ----------------------------------------------------------------------------
// rbs_bit_chain
// Row of bit cells; shifts toward the MSB, which is presented to the unit.
// ----------------------------------------------------------------------------
module rbs_bit_chain import rbs_pkg::*; (
  input  logic  clk_i,
  input  logic  load_i,
  input  logic  shift_i,
  input  word_t din_i,
  output logic  msb_o
);

  logic [WORD_WIDTH-1:0] bits;

  for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b0;
    end else begin : g_rest
      assign prev = bits[i-1];
    end
    rbs_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load_i),
      .shift_i    (shift_i),
      .load_bit_i (din_i[i]),
      .prev_bit_i (prev),
      .bit_o      (bits[i])
    );
  end

  assign msb_o = bits[WORD_WIDTH-1];

endmodule

[design/rbs_mulmod.sv]
// ----------------------------------------------------------------------------
// rbs_mulmod
// Modular multiplier, double-and-add, a doubling phase and an add phase per multiplier bit.
// ----------------------------------------------------------------------------
module rbs_mulmod import rbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  word_t     x_i,
  input  word_t     y_i,
  input  word_t     n_i,
  output logic      done_o,
  output word_t     prod_o
);

  word_t acc_q, acc_d;
  word_t x_q, x_d;
  cnt_t  cnt_q, cnt_d;
  logic  busy_q, busy_d;
  logic  phase_q, phase_d;
  logic  done_q, done_d;
  logic  ybit, shift;
  word_t sum;

  rbs_bit_chain u_chain (
    .clk_i   (clk_i),
    .load_i  (req_i.start),
    .shift_i (shift),
    .din_i   (y_i),
    .msb_o   (ybit)
  );

  // phase 0 doubles, phase 1 conditionally adds x
  assign sum   = add_mod(acc_q, phase_q ? x_q : acc_q, n_i);
  assign shift = busy_q & phase_q;

  always_comb begin
    acc_d   = acc_q;
    x_d     = x_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      acc_d   = '0;
      x_d     = x_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
      phase_d = 1'b0;
    end else if (busy_q) begin
      phase_d = ~phase_q;
      if (!phase_q || ybit) begin
        acc_d = sum;
      end
      if (phase_q) begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[design/rbs_divider.sv]
// ----------------------------------------------------------------------------
// rbs_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbs_divider import rbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  word_t     dividend_i,
  input  word_t     divisor_i,
  output logic      done_o,
  output word_t     quo_o,
  output word_t     rem_o
);

  word_t rem_q, rem_d;
  word_t quo_q, quo_d;
  word_t div_q, div_d;
  cnt_t  cnt_q, cnt_d;
  logic  busy_q, busy_d;
  logic  done_q, done_d;
  logic  nbit;
  logic [WORD_WIDTH:0] trial;

  rbs_bit_chain u_chain (
    .clk_i   (clk_i),
    .load_i  (req_i.start),
    .shift_i (busy_q),
    .din_i   (dividend_i),
    .msb_o   (nbit)
  );

  assign trial = {rem_q, nbit};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = '0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = WORD_WIDTH'(trial - {1'b0, div_q});
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[WORD_WIDTH-1:0];
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[design/rsa_blind_signature_unit.sv]
// ----------------------------------------------------------------------------
// rsa_blind_signature_unit
// Modular arithmetic engine for blind RSA: blind, sign, unblind and verify.
// ----------------------------------------------------------------------------
// One item is worked at a time; a new item is taken once the previous one has
// left the sequencer, while its result may still wait in the output register.
// Work is done by the shared modular multiplier (operand bits fed through a
// chain of bit cells) and the shift-subtract divider. Exponentiation runs a
// multiply for each set exponent bit and a squaring for each bit position up
// to the top set bit, after a reduction of the operands. Unblind runs
// extended Euclid, with one division and one multiplication per quotient step.
// A modulus below two goes straight from idle to the done state.
module rsa_blind_signature_unit import rbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_addr_i,
  input  word_t                cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  word_t                data_word_i,
  input  word_t                aux_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output word_t                result_word_o,
  output logic                 sig_valid_o,
  output logic                 no_inverse_o
);

  state_e state_q, state_d;
  word_t  mod_q, pub_q, priv_q;
  kind_e  kind_q;
  word_t  data_q, aux_q, a_q, b_q, acc_q, exp_q;
  word_t  r0_q, r1_q, t0_q, t1_q, q_q, rn_q, qt_q;
  word_t  res_q;
  logic   sig_q, noinv_q;
  logic   run_q;
  logic   out_valid_q;
  word_t  out_res_q;
  logic   out_sig_q, out_noinv_q;

  unit_req_t mul_req, div_req;
  word_t     mul_x, mul_y, mul_p;
  word_t     div_n, div_d, div_quo, div_rem;
  logic      mul_done, div_done;
  logic      in_xfer, out_free, small_mod, use_mul, use_div;
  word_t     q_red;

  assign in_xfer   = in_valid_i & in_ready_o;
  assign out_free  = ~out_valid_q | out_ready_i;
  assign small_mod = (mod_q[WORD_WIDTH-1:1] == '0);
  assign q_red     = (div_quo >= mod_q) ? div_quo - mod_q : div_quo;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MODULUS_RST;
      pub_q  <= PUB_EXP_RST;
      priv_q <= PRIV_EXP_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_MODULUS:  mod_q  <= cfg_wdata_i;
        REG_PUB_EXP:  pub_q  <= cfg_wdata_i;
        REG_PRIV_EXP: priv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (small_mod) begin
            state_d = ST_DONE;
          end else if (kind_e'(kind_i) == KIND_BLIND || kind_e'(kind_i) == KIND_UNBLIND) begin
            state_d = ST_RED_A;
          end else begin
            state_d = ST_RED_B;
          end
        end
      end
      ST_RED_A:   if (div_done) state_d = ST_RED_B;
      ST_RED_B: begin
        if (div_done) begin
          state_d = (kind_q == KIND_UNBLIND) ? ST_INV_CHK : ST_POW_CHK;
        end
      end
      ST_POW_CHK: begin
        if (exp_q == '0) begin
          state_d = (kind_q == KIND_BLIND) ? ST_FIN_MUL : ST_DONE;
        end else begin
          state_d = exp_q[0] ? ST_POW_MUL : ST_POW_SQR;
        end
      end
      ST_POW_MUL: if (mul_done) state_d = ST_POW_SQR;
      ST_POW_SQR: if (mul_done) state_d = ST_POW_CHK;
      ST_INV_CHK: begin
        if (r1_q != '0) begin
          state_d = ST_INV_DIV;
        end else begin
          state_d = (r0_q == word_t'(1)) ? ST_FIN_MUL : ST_DONE;
        end
      end
      ST_INV_DIV: if (div_done) state_d = ST_INV_MUL;
      ST_INV_MUL: if (mul_done) state_d = ST_INV_UPD;
      ST_INV_UPD: state_d = ST_INV_CHK;
      ST_FIN_MUL: if (mul_done) state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    use_mul = 1'b0;
    use_div = 1'b0;
    mul_x   = acc_q;
    mul_y   = b_q;
    div_n   = data_q;
    div_d   = mod_q;
    case (state_q)
      ST_RED_A: begin
        use_div = 1'b1;
      end
      ST_RED_B: begin
        use_div = 1'b1;
        div_n   = (kind_q == KIND_SIGN) ? data_q : aux_q;
      end
      ST_INV_DIV: begin
        use_div = 1'b1;
        div_n   = r0_q;
        div_d   = r1_q;
      end
      ST_POW_MUL: begin
        use_mul = 1'b1;
      end
      ST_POW_SQR: begin
        use_mul = 1'b1;
        mul_x   = b_q;
      end
      ST_INV_MUL: begin
        use_mul = 1'b1;
        mul_x   = q_q;
        mul_y   = t1_q;
      end
      ST_FIN_MUL: begin
        use_mul = 1'b1;
        mul_x   = a_q;
        mul_y   = acc_q;
      end
      default: ;
    endcase
    mul_req.start = use_mul & ~run_q;
    div_req.start = use_div & ~run_q;
  end

  rbs_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .n_i    (mod_q),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  rbs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_req.start || div_req.start) begin
        run_q <= 1'b1;
      end else if (mul_done || div_done) begin
        run_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        kind_q  <= kind_e'(kind_i);
        data_q  <= data_word_i;
        aux_q   <= aux_word_i;
        res_q   <= '0;
        noinv_q <= 1'b0;
        sig_q   <= (kind_e'(kind_i) == KIND_VERIFY) && (data_word_i == '0);
      end
      ST_RED_A: if (div_done) a_q <= div_rem;
      ST_RED_B: begin
        if (div_done) begin
          b_q   <= div_rem;
          acc_q <= word_t'(1);
          exp_q <= (kind_q == KIND_SIGN) ? priv_q : pub_q;
          r0_q  <= mod_q;
          r1_q  <= div_rem;
          t0_q  <= '0;
          t1_q  <= word_t'(1);
        end
      end
      ST_POW_CHK: begin
        if (exp_q == '0) begin
          res_q <= (kind_q == KIND_SIGN) ? acc_q : '0;
          sig_q <= (kind_q == KIND_VERIFY) && (acc_q == data_q);
        end
      end
      ST_POW_MUL: if (mul_done) acc_q <= mul_p;
      ST_POW_SQR: begin
        if (mul_done) begin
          b_q   <= mul_p;
          exp_q <= exp_q >> 1;
        end
      end
      ST_INV_CHK: begin
        if (r1_q == '0) begin
          acc_q   <= t0_q;
          noinv_q <= (r0_q != word_t'(1));
        end
      end
      ST_INV_DIV: begin
        if (div_done) begin
          q_q  <= q_red;
          rn_q <= div_rem;
        end
      end
      ST_INV_MUL: if (mul_done) qt_q <= mul_p;
      ST_INV_UPD: begin
        // t0 - qt taken mod n; the result lies in [0, n)
        t1_q <= (t0_q >= qt_q) ? t0_q - qt_q : t0_q - qt_q + mod_q;
        t0_q <= t1_q;
        r0_q <= r1_q;
        r1_q <= rn_q;
      end
      ST_FIN_MUL: if (mul_done) res_q <= mul_p;
      ST_DONE: begin
        if (out_free) begin
          out_res_q   <= res_q;
          out_sig_q   <= sig_q;
          out_noinv_q <= noinv_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_res_q;
  assign sig_valid_o   = out_sig_q;
  assign no_inverse_o  = out_noinv_q;

  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_inverse_o |-> result_word_o == '0)
    else $error("no_inverse with nonzero result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sig_valid_o && no_inverse_o))
    else $error("sig_valid and no_inverse both set");

  a_mul_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> run_q)
    else $error("multiplier done without a request");

  a_div_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> run_q)
    else $error("divider done without a request");

endmodule
